/* src/cda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Shared widths, codes, bus structs and calendar helper functions.
// ----------------------------------------------------------------------------
package cda_pkg;

	// Default last valid year.
	localparam int unsigned MAX_YEAR_DEF = 9999;

	// Widths of the ports and of the internal day numbers and years.
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned DAYS_W  = 22;
	localparam int unsigned COUNT_W = 22;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned SER_W   = 25;
	localparam int unsigned YR_W    = 16;
	localparam int unsigned CYC_W   = 9;

	// Days in one full Gregorian 400 year cycle, and the saturation value.
	localparam logic [SER_W-1:0]  DAYS_400  = SER_W'(146097);
	localparam logic [DAYS_W-1:0] DAYS_MAX  = '1;
	localparam logic [CYC_W-1:0]  CYC_LEN   = CYC_W'(400);

	typedef logic [SER_W-1:0] ser_t;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_ADD  = 2'd0,
		REQ_SUB  = 2'd1,
		REQ_DIFF = 2'd2,
		REQ_DOY  = 2'd3
	} req_t;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_DATE = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

	// Operands of the shared add/subtract unit.
	typedef struct packed {
		ser_t a;
		ser_t b;
		logic sub;
	} alu_req_t;

	// Result of the shared unit; borrow is set when a subtraction goes negative.
	typedef struct packed {
		ser_t sum;
		logic borrow;
	} alu_rsp_t;

	// One finished result item.
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [DAYS_W-1:0]  days;
		logic [STAT_W-1:0]  status;
	} res_t;

	// Leap test for a year given by its place 1..400 in the 400 year cycle.
	function automatic logic leap_in_cycle(input logic [CYC_W-1:0] c);
		return (c[1:0] == 2'b00) && (c != CYC_W'(100)) && (c != CYC_W'(200))
			&& (c != CYC_W'(300));
	endfunction

	// Length of a year given by its place in the 400 year cycle.
	function automatic ser_t year_len(input logic [CYC_W-1:0] c);
		return leap_in_cycle(c) ? SER_W'(366) : SER_W'(365);
	endfunction

	// Length of a month; only meaningful for months 1..12.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

endpackage

/* src/cda_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic shared unit
// One day-number adder/subtractor with borrow, used by the sequencer's arithmetic steps.
// ----------------------------------------------------------------------------
module cda_alu (
	input  cda_pkg::alu_req_t op,
	output cda_pkg::alu_rsp_t rsp
);

	logic                  carry;
	logic [cda_pkg::SER_W-1:0] b_eff;

	// Subtraction is an add of the inverted operand with carry in.
	assign b_eff = op.sub ? ~op.b : op.b;
	assign {carry, rsp.sum} = {1'b0, op.a} + {1'b0, b_eff}
		+ {{cda_pkg::SER_W{1'b0}}, op.sub};

	// A subtraction without carry out went below zero.
	assign rsp.borrow = op.sub & ~carry;

endmodule

/* src/cda_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic sequencer
// Walks dates to day numbers and back in 400 year, year and month steps,
// driving the shared adder once per cycle.
// ----------------------------------------------------------------------------
module cda_seq #(
	parameter int unsigned MAX_YEAR = cda_pkg::MAX_YEAR_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    req_type,
	input  logic [cda_pkg::YEAR_W-1:0]    year_a,
	input  logic [cda_pkg::MONTH_W-1:0]   month_a,
	input  logic [cda_pkg::DAY_W-1:0]     day_a,
	input  logic [cda_pkg::COUNT_W-1:0]   day_count,
	input  logic [cda_pkg::YEAR_W-1:0]    year_b,
	input  logic [cda_pkg::MONTH_W-1:0]   month_b,
	input  logic [cda_pkg::DAY_W-1:0]     day_b,
	input  logic                          res_free,
	output logic                          idle,
	output logic                          done,
	output cda_pkg::res_t                 result,
	output cda_pkg::alu_req_t             alu_op,
	input  cda_pkg::alu_rsp_t             alu_rsp
);

	localparam logic [cda_pkg::YR_W-1:0] MAX_YR = cda_pkg::YR_W'(MAX_YEAR);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_Y400,
		S_Y1,
		S_VAL,
		S_MON,
		S_DAY,
		S_DISP,
		S_ADDC,
		S_SUBC,
		S_D400,
		S_D1,
		S_DM,
		S_DIF1,
		S_DIF2,
		S_FIN
	} state_t;

	state_t                        state_q;
	cda_pkg::req_t                 req_q;
	logic [cda_pkg::YEAR_W-1:0]    ya_q, yb_q;
	logic [cda_pkg::MONTH_W-1:0]   ma_q, mb_q;
	logic [cda_pkg::DAY_W-1:0]     da_q, db_q;
	logic [cda_pkg::COUNT_W-1:0]   cnt_q;
	logic                          sel_b_q;
	cda_pkg::ser_t                 acc_q;
	cda_pkg::ser_t                 sa_q;
	logic [cda_pkg::YEAR_W-1:0]    rem_q;
	logic [cda_pkg::CYC_W-1:0]     cyc_q;
	logic [cda_pkg::MONTH_W-1:0]   mon_q;
	logic [cda_pkg::YR_W-1:0]      yel_q;
	logic                          leap_q;
	logic [cda_pkg::STAT_W-1:0]    status_q;

	logic [cda_pkg::YEAR_W-1:0]    cur_y;
	logic [cda_pkg::MONTH_W-1:0]   cur_m;
	logic [cda_pkg::DAY_W-1:0]     cur_d;
	logic                          cur_ok;
	logic [cda_pkg::YR_W:0]        yr_next;
	logic [cda_pkg::YR_W-1:0]      res_yr;

	// Date being converted: A first, B for the second half of a difference.
	assign cur_y = sel_b_q ? yb_q : ya_q;
	assign cur_m = sel_b_q ? mb_q : ma_q;
	assign cur_d = sel_b_q ? db_q : da_q;

	// Month and day check, once the leap flag of the year is known.
	assign cur_ok = (cur_m != '0) && (cur_m <= 4'd12) && (cur_d != '0)
		&& (cur_d <= cda_pkg::month_len(cur_m, leap_q));

	// Resulting year of a date conversion, one wider to compare safely.
	assign yr_next = {1'b0, yel_q} + {{cda_pkg::YR_W{1'b0}}, 1'b1};

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_FIN);

	// Operand selection for the shared adder.
	always_comb begin
		alu_op.a   = acc_q;
		alu_op.b   = '0;
		alu_op.sub = 1'b0;
		unique case (state_q)
			S_Y400: begin
				alu_op.b = cda_pkg::DAYS_400;
			end
			S_Y1: begin
				alu_op.b = cda_pkg::year_len(cyc_q);
			end
			S_MON: begin
				alu_op.b = cda_pkg::SER_W'(cda_pkg::month_len(mon_q, leap_q));
			end
			S_DAY: begin
				alu_op.b = (req_q == cda_pkg::REQ_DOY) ? cda_pkg::SER_W'(cur_d)
					: cda_pkg::SER_W'(cur_d - 5'd1);
			end
			S_ADDC: begin
				alu_op.b = cda_pkg::SER_W'(cnt_q);
			end
			S_SUBC: begin
				alu_op.b   = cda_pkg::SER_W'(cnt_q);
				alu_op.sub = 1'b1;
			end
			S_D400: begin
				alu_op.b   = cda_pkg::DAYS_400;
				alu_op.sub = 1'b1;
			end
			S_D1: begin
				alu_op.b   = cda_pkg::year_len(cyc_q);
				alu_op.sub = 1'b1;
			end
			S_DM: begin
				alu_op.b   = cda_pkg::SER_W'(cda_pkg::month_len(mon_q, leap_q));
				alu_op.sub = 1'b1;
			end
			S_DIF1: begin
				alu_op.b   = sa_q;
				alu_op.sub = 1'b1;
			end
			S_DIF2: begin
				alu_op.a   = sa_q;
				alu_op.b   = acc_q;
				alu_op.sub = 1'b1;
			end
			default: begin
				alu_op.b = '0;
			end
		endcase
	end

	// Result fields from the final registers.
	assign res_yr = yr_next[cda_pkg::YR_W-1:0];
	always_comb begin
		result        = '0;
		result.status = status_q;
		if (status_q == cda_pkg::ST_OK) begin
			if (req_q == cda_pkg::REQ_ADD || req_q == cda_pkg::REQ_SUB) begin
				result.year  = res_yr[cda_pkg::YEAR_W-1:0];
				result.month = mon_q;
				result.day   = acc_q[cda_pkg::DAY_W-1:0] + 5'd1;
			end else begin
				result.days = (|acc_q[cda_pkg::SER_W-1:cda_pkg::DAYS_W]) ? cda_pkg::DAYS_MAX
					: acc_q[cda_pkg::DAYS_W-1:0];
			end
		end
	end

	// Sequencer state and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= cda_pkg::req_t'(req_type);
						ya_q     <= year_a;
						ma_q     <= month_a;
						da_q     <= day_a;
						cnt_q    <= day_count;
						yb_q     <= year_b;
						mb_q     <= month_b;
						db_q     <= day_b;
						sel_b_q  <= 1'b0;
						status_q <= cda_pkg::ST_OK;
						state_q  <= S_CHK;
					end
				end
				S_CHK: begin
					if (cur_y == '0 || {2'b00, cur_y} > MAX_YR) begin
						status_q <= cda_pkg::ST_BAD_DATE;
						state_q  <= S_FIN;
					end else begin
						acc_q   <= '0;
						rem_q   <= cur_y - 14'd1;
						cyc_q   <= cda_pkg::CYC_W'(1);
						mon_q   <= 4'd1;
						state_q <= S_Y400;
					end
				end
				// Whole 400 year cycles before the year.
				S_Y400: begin
					if (rem_q >= 14'd400) begin
						acc_q <= alu_rsp.sum;
						rem_q <= rem_q - 14'd400;
					end else begin
						state_q <= S_Y1;
					end
				end
				// Single years before the year, inside its cycle.
				S_Y1: begin
					if (rem_q != '0) begin
						acc_q <= alu_rsp.sum;
						rem_q <= rem_q - 14'd1;
						cyc_q <= cyc_q + 9'd1;
					end else begin
						leap_q <= cda_pkg::leap_in_cycle(cyc_q);
						if (req_q == cda_pkg::REQ_DOY) begin
							acc_q <= '0;
						end
						state_q <= S_VAL;
					end
				end
				S_VAL: begin
					if (!cur_ok) begin
						status_q <= cda_pkg::ST_BAD_DATE;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_MON;
					end
				end
				// Whole months before the month.
				S_MON: begin
					if (mon_q < cur_m) begin
						acc_q <= alu_rsp.sum;
						mon_q <= mon_q + 4'd1;
					end else begin
						state_q <= S_DAY;
					end
				end
				S_DAY: begin
					acc_q   <= alu_rsp.sum;
					state_q <= S_DISP;
				end
				S_DISP: begin
					unique case (req_q)
						cda_pkg::REQ_ADD: begin
							state_q <= S_ADDC;
						end
						cda_pkg::REQ_SUB: begin
							state_q <= S_SUBC;
						end
						cda_pkg::REQ_DIFF: begin
							if (sel_b_q) begin
								state_q <= S_DIF1;
							end else begin
								sa_q    <= acc_q;
								sel_b_q <= 1'b1;
								state_q <= S_CHK;
							end
						end
						cda_pkg::REQ_DOY: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_ADDC: begin
					acc_q   <= alu_rsp.sum;
					yel_q   <= '0;
					cyc_q   <= cda_pkg::CYC_W'(1);
					mon_q   <= 4'd1;
					state_q <= S_D400;
				end
				S_SUBC: begin
					if (alu_rsp.borrow) begin
						status_q <= cda_pkg::ST_RANGE;
						state_q  <= S_FIN;
					end else begin
						acc_q   <= alu_rsp.sum;
						yel_q   <= '0;
						cyc_q   <= cda_pkg::CYC_W'(1);
						mon_q   <= 4'd1;
						state_q <= S_D400;
					end
				end
				// Day number back to a date: cycles, years, then months.
				S_D400: begin
					if (!alu_rsp.borrow) begin
						acc_q <= alu_rsp.sum;
						yel_q <= yel_q + cda_pkg::YR_W'(400);
					end else begin
						state_q <= S_D1;
					end
				end
				S_D1: begin
					if (!alu_rsp.borrow) begin
						acc_q <= alu_rsp.sum;
						yel_q <= yel_q + cda_pkg::YR_W'(1);
						cyc_q <= cyc_q + 9'd1;
					end else begin
						leap_q <= cda_pkg::leap_in_cycle(cyc_q);
						if (yr_next > {1'b0, MAX_YR}) begin
							status_q <= cda_pkg::ST_RANGE;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_DM;
						end
					end
				end
				S_DM: begin
					if (!alu_rsp.borrow && mon_q < 4'd12) begin
						acc_q <= alu_rsp.sum;
						mon_q <= mon_q + 4'd1;
					end else begin
						state_q <= S_FIN;
					end
				end
				// Absolute difference of the two day numbers.
				S_DIF1: begin
					if (alu_rsp.borrow) begin
						state_q <= S_DIF2;
					end else begin
						acc_q   <= alu_rsp.sum;
						state_q <= S_FIN;
					end
				end
				S_DIF2: begin
					acc_q   <= alu_rsp.sum;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/calendar_date_arithmetic_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic
// Gregorian date add, subtract, day difference and day of year unit.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   request | req_valid, req_ready | req_type, year_a, month_a, day_a,
//           |                      | day_count, year_b, month_b, day_b
//   result  | res_valid, res_ready | res_year, res_month, res_day, res_days,
//           |                      | status
//
// One item at a time; the shared day-number adder does one step per cycle.
// Converting a date y-m-d steps through the 400 year cycles, the single years
// and the months before it, and turning a day number s back into a date steps
// through 400 year cycles, the years into its cycle and the months. Reset
// clears the sequencer and the result valid flag.
// A result waiting in the output register holds the sequencer in its final
// step, while the output register itself lets the result sit until taken.
//
module calendar_date_arithmetic_top #(
	parameter int unsigned MAX_YEAR = cda_pkg::MAX_YEAR_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    req_type,
	input  logic [cda_pkg::YEAR_W-1:0]    year_a,
	input  logic [cda_pkg::MONTH_W-1:0]   month_a,
	input  logic [cda_pkg::DAY_W-1:0]     day_a,
	input  logic [cda_pkg::COUNT_W-1:0]   day_count,
	input  logic [cda_pkg::YEAR_W-1:0]    year_b,
	input  logic [cda_pkg::MONTH_W-1:0]   month_b,
	input  logic [cda_pkg::DAY_W-1:0]     day_b,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [cda_pkg::YEAR_W-1:0]    res_year,
	output logic [cda_pkg::MONTH_W-1:0]   res_month,
	output logic [cda_pkg::DAY_W-1:0]     res_day,
	output logic [cda_pkg::DAYS_W-1:0]    res_days,
	output logic [cda_pkg::STAT_W-1:0]    status
);

	cda_pkg::alu_req_t alu_op;
	cda_pkg::alu_rsp_t alu_rsp;
	cda_pkg::res_t     seq_res;
	cda_pkg::res_t     res_q;
	logic              res_valid_q;
	logic              seq_idle;
	logic              seq_done;
	logic              res_free;
	logic              start;

	assign req_ready = seq_idle;
	assign start     = req_valid && seq_idle;
	assign res_free  = !res_valid_q || res_ready;

	// Shared day-number adder.
	cda_alu u_alu (
		.op  (alu_op),
		.rsp (alu_rsp)
	);

	// Step sequencer.
	cda_seq #(
		.MAX_YEAR (MAX_YEAR)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.year_a    (year_a),
		.month_a   (month_a),
		.day_a     (day_a),
		.day_count (day_count),
		.year_b    (year_b),
		.month_b   (month_b),
		.day_b     (day_b),
		.res_free  (res_free),
		.idle      (seq_idle),
		.done      (seq_done),
		.result    (seq_res),
		.alu_op    (alu_op),
		.alu_rsp   (alu_rsp)
	);

	// Output register: loads a finished item when the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (seq_done && res_free) begin
				res_valid_q <= 1'b1;
				res_q       <= seq_res;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_year  = res_q.year;
	assign res_month = res_q.month;
	assign res_day   = res_q.day;
	assign res_days  = res_q.days;
	assign status    = res_q.status;

	// The unit is not ready in the cycle after it takes an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while the previous item was still in work");

	// A failed item carries no date and no day count.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != cda_pkg::ST_OK) |->
		(res_year == '0 && res_month == '0 && res_day == '0 && res_days == '0))
		else $error("failed result carries nonzero fields");

	// A date result has a month and day in range and no day count.
	a_date_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status == cda_pkg::ST_OK && res_month != '0) |->
		(res_days == '0 && res_day != '0 && res_month <= 4'd12))
		else $error("date result out of shape");

	// A finished item stays in the sequencer while the output slot is full and not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready && seq_done) |=> (seq_done && res_valid_q))
		else $error("finished item dropped while output slot was full");

endmodule

/* sim/calendar_date_arithmetic_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic testbench
// Drives add, subtract, difference and day of year requests into the unit.
// The requests are directed corner cases first and then random traffic with
// random gaps on both channels. A Gregorian calendar predictor computes each
// expected item, and every result item is checked against it field by field.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_top_tb;

	localparam int unsigned CAL_LAST_YEAR = cda_pkg::MAX_YEAR_DEF;
	localparam int unsigned DRAIN_CYCLES = 1100;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef logic [cda_pkg::YEAR_W-1:0]  year_t;
	typedef logic [cda_pkg::MONTH_W-1:0] month_t;
	typedef logic [cda_pkg::DAY_W-1:0]   mday_t;
	typedef logic [cda_pkg::COUNT_W-1:0] count_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   req_valid = 1'b0;
	logic   req_ready;
	logic   [1:0] req_type = '0;
	year_t  year_a = '0;
	month_t month_a = '0;
	mday_t  day_a = '0;
	count_t day_count = '0;
	year_t  year_b = '0;
	month_t month_b = '0;
	mday_t  day_b = '0;
	logic   res_valid;
	logic   res_ready = 1'b0;
	year_t  res_year;
	month_t res_month;
	mday_t  res_day;
	logic   [cda_pkg::DAYS_W-1:0] res_days;
	logic   [cda_pkg::STAT_W-1:0] status;

	cda_pkg::res_t expected_results[$];
	int unsigned   mismatch_count = 0;
	bit            no_idle = 1'b0;

	calendar_date_arithmetic_top #(
		.MAX_YEAR(CAL_LAST_YEAR)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.year_a(year_a),
		.month_a(month_a),
		.day_a(day_a),
		.day_count(day_count),
		.year_b(year_b),
		.month_b(month_b),
		.day_b(day_b),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_year(res_year),
		.res_month(res_month),
		.res_day(res_day),
		.res_days(res_days),
		.status(status)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Gregorian calendar predictor
	// ------------------------------------------------------------------

	function automatic bit leap_year(input longint unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(input longint unsigned y,
			input longint unsigned m);
		int unsigned len;
		case (m)
			2: begin
				len = leap_year(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				len = 30;
			end
			default: begin
				len = 31;
			end
		endcase
		return len;
	endfunction

	function automatic bit date_is_valid(input longint unsigned y,
			input longint unsigned m, input longint unsigned d);
		if (y < 1 || y > CAL_LAST_YEAR || m < 1 || m > 12)
			return 1'b0;
		return d >= 1 && d <= month_days(y, m);
	endfunction

	// Day of year, 1 on the first of January.
	function automatic longint unsigned day_in_year(input longint unsigned y,
			input longint unsigned m, input longint unsigned d);
		longint unsigned n;
		n = d;
		for (longint unsigned i = 1; i < m; i++)
			n += month_days(y, i);
		return n;
	endfunction

	// Running day number, 0 on 0001-01-01.
	function automatic longint unsigned day_number(input longint unsigned y,
			input longint unsigned m, input longint unsigned d);
		longint unsigned p;
		p = y - 1;
		return p * 365 + p / 4 - p / 100 + p / 400 + day_in_year(y, m, d) - 1;
	endfunction

	// Splits a day number into 400, 100, 4 and 1 year cycles, then months.
	function automatic void date_of_day_number(input longint unsigned s,
			output longint unsigned y, output longint unsigned m,
			output longint unsigned d);
		longint unsigned rest, q400, q100, q4, q1;
		q400 = s / 146097;
		rest = s % 146097;
		q100 = rest / 36524;
		if (q100 == 4)
			q100 = 3;
		rest -= q100 * 36524;
		q4 = rest / 1461;
		rest %= 1461;
		q1 = rest / 365;
		if (q1 == 4)
			q1 = 3;
		rest -= q1 * 365;
		y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
		m = 1;
		while (m < 12 && rest >= month_days(y, m)) begin
			rest -= month_days(y, m);
			m++;
		end
		d = rest + 1;
	endfunction

	function automatic cda_pkg::res_t predict_calendar(input cda_pkg::req_t kind,
			input year_t ya, input month_t ma, input mday_t da, input count_t cnt,
			input year_t yb, input month_t mb, input mday_t db);
		cda_pkg::res_t r;
		longint unsigned sa, sb, s, gap, y, m, d;
		r = '0;
		r.status = cda_pkg::ST_OK;
		if (!date_is_valid(ya, ma, da)) begin
			r.status = cda_pkg::ST_BAD_DATE;
		end else begin
			case (kind)
				cda_pkg::REQ_ADD, cda_pkg::REQ_SUB: begin
					sa = day_number(ya, ma, da);
					if (kind == cda_pkg::REQ_SUB && sa < cnt) begin
						r.status = cda_pkg::ST_RANGE;
					end else begin
						s = (kind == cda_pkg::REQ_ADD) ? sa + cnt : sa - cnt;
						date_of_day_number(s, y, m, d);
						if (y > CAL_LAST_YEAR) begin
							r.status = cda_pkg::ST_RANGE;
						end else begin
							r.year  = year_t'(y);
							r.month = month_t'(m);
							r.day   = mday_t'(d);
						end
					end
				end
				cda_pkg::REQ_DIFF: begin
					if (!date_is_valid(yb, mb, db)) begin
						r.status = cda_pkg::ST_BAD_DATE;
					end else begin
						sa = day_number(ya, ma, da);
						sb = day_number(yb, mb, db);
						gap = (sa >= sb) ? sa - sb : sb - sa;
						r.days = (gap > cda_pkg::DAYS_MAX) ? cda_pkg::DAYS_MAX
							: cda_pkg::DAYS_W'(gap);
					end
				end
				default: begin
					r.days = cda_pkg::DAYS_W'(day_in_year(ya, ma, da));
				end
			endcase
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sends one request item and records its expected result on acceptance.
	task automatic send_request(input cda_pkg::req_t kind, input year_t ya,
			input month_t ma, input mday_t da, input count_t cnt, input year_t yb,
			input month_t mb, input mday_t db);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		year_a    <= ya;
		month_a   <= ma;
		day_a     <= da;
		day_count <= cnt;
		year_b    <= yb;
		month_b   <= mb;
		day_b     <= db;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		expected_results.push_back(predict_calendar(kind, ya, ma, da, cnt, yb, mb, db));
	endtask

	// A legal date, biased toward the first and last year, toward centuries and toward month ends.
	function automatic void pick_valid_date(output year_t y, output month_t m,
			output mday_t d);
		int unsigned len;
		case ($urandom_range(0, 11))
			0: begin
				y = year_t'(1);
			end
			1: begin
				y = year_t'(CAL_LAST_YEAR);
			end
			2: begin
				y = year_t'(100 * $urandom_range(1, CAL_LAST_YEAR / 100));
			end
			default: begin
				y = year_t'($urandom_range(1, CAL_LAST_YEAR));
			end
		endcase
		m = month_t'($urandom_range(1, 12));
		len = month_days(y, m);
		d = ($urandom_range(0, 3) == 0) ? mday_t'(len) : mday_t'($urandom_range(1, len));
	endfunction

	// One random request: mostly legal dates, some broken dates, some noise.
	task automatic send_random_request();
		cda_pkg::req_t kind;
		year_t         ya, yb;
		month_t        ma, mb;
		mday_t         da, db;
		count_t        cnt;
		int unsigned   roll;
		kind = cda_pkg::req_t'($urandom_range(0, 3));
		roll = $urandom_range(0, 99);
		pick_valid_date(ya, ma, da);
		pick_valid_date(yb, mb, db);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				cnt = count_t'($urandom_range(0, 400));
			end
			5, 6, 7: begin
				cnt = count_t'($urandom_range(0, 40000));
			end
			default: begin
				cnt = count_t'($urandom());
			end
		endcase
		if (roll < 10) begin
			// Arbitrary bits in every field.
			{ya, ma, da} = (cda_pkg::YEAR_W + cda_pkg::MONTH_W + cda_pkg::DAY_W)'($urandom());
			{yb, mb, db} = (cda_pkg::YEAR_W + cda_pkg::MONTH_W + cda_pkg::DAY_W)'($urandom());
			cnt = count_t'($urandom());
		end else if (roll < 22) begin
			// One field of a date just outside its legal range.
			case ($urandom_range(0, 3))
				0: begin
					da = '0;
				end
				1: begin
					ma = ($urandom_range(0, 1) == 0) ? month_t'(0)
						: month_t'($urandom_range(13, 15));
				end
				2: begin
					ya = ($urandom_range(0, 1) == 0) ? year_t'(0)
						: year_t'($urandom_range(CAL_LAST_YEAR + 1,
						(1 << cda_pkg::YEAR_W) - 1));
				end
				default: begin
					da = (month_days(ya, ma) < 31) ? mday_t'(month_days(ya, ma) + 1) : '0;
				end
			endcase
			// For a difference the broken date may be the second one.
			if (kind == cda_pkg::REQ_DIFF && $urandom_range(0, 1) == 1)
				{ya, ma, da, yb, mb, db} = {yb, mb, db, ya, ma, da};
		end else if (roll < 35) begin
			// Dates close together.
			yb = ya;
		end
		send_request(kind, ya, ma, da, cnt, yb, mb, db);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Month, year and range ends when adding.
	task automatic test_add_days();
		send_request(cda_pkg::REQ_ADD, 1, 1, 1, 0, 0, 0, 0);
		send_request(cda_pkg::REQ_ADD, 9999, 12, 31, 0, 0, 0, 0);
		send_request(cda_pkg::REQ_ADD, 9999, 12, 31, 1, 0, 0, 0);
		send_request(cda_pkg::REQ_ADD, 1, 1, 1, '1, 0, 0, 0);
		send_request(cda_pkg::REQ_ADD, 2024, 1, 31, 1, 0, 0, 0);
		send_request(cda_pkg::REQ_ADD, 2023, 2, 28, 1, 0, 0, 0);
		send_request(cda_pkg::REQ_ADD, 2024, 2, 28, 1, 0, 0, 0);
		send_request(cda_pkg::REQ_ADD, 2024, 12, 31, 1, 0, 0, 0);
	endtask

	// Backward counting across month and year ends and below the first day.
	task automatic test_subtract_days();
		send_request(cda_pkg::REQ_SUB, 1, 1, 1, 1, 0, 0, 0);
		send_request(cda_pkg::REQ_SUB, 2024, 3, 1, 1, 0, 0, 0);
		send_request(cda_pkg::REQ_SUB, 2000, 1, 1, 1, 0, 0, 0);
		send_request(cda_pkg::REQ_SUB, 9999, 12, 31, 3652058, 0, 0, 0);
	endtask

	// Full range span, equal dates, a bad second date and either order.
	task automatic test_difference();
		send_request(cda_pkg::REQ_DIFF, 1, 1, 1, 0, 9999, 12, 31);
		send_request(cda_pkg::REQ_DIFF, 2024, 2, 29, 0, 2024, 2, 29);
		send_request(cda_pkg::REQ_DIFF, 2024, 2, 29, 0, 2024, 13, 1);
		send_request(cda_pkg::REQ_DIFF, 2024, 3, 1, 0, 2023, 3, 1);
	endtask

	// Leap and common years, and a century that is not a leap year.
	task automatic test_day_of_year();
		send_request(cda_pkg::REQ_DOY, 2024, 12, 31, 0, 0, 0, 0);
		send_request(cda_pkg::REQ_DOY, 2023, 12, 31, 0, 0, 0, 0);
		send_request(cda_pkg::REQ_DOY, 1900, 3, 1, 0, 0, 0, 0);
	endtask

	// First dates with a zero or too large year, a zero month, a zero or too large day, and a legal leap day.
	task automatic test_invalid_dates();
		send_request(cda_pkg::REQ_ADD, 0, 6, 15, 1, 0, 0, 0);
		send_request(cda_pkg::REQ_SUB, '1, 6, 15, 1, 0, 0, 0);
		send_request(cda_pkg::REQ_DOY, 2023, 0, 15, 0, 0, 0, 0);
		send_request(cda_pkg::REQ_DIFF, 2023, 6, 0, 0, 2023, 6, 1);
		send_request(cda_pkg::REQ_ADD, 2023, 4, 31, 0, 0, 0, 0);
		send_request(cda_pkg::REQ_DOY, 1900, 2, 29, 0, 0, 0, 0);
		send_request(cda_pkg::REQ_DOY, 2000, 2, 29, 0, 0, 0, 0);
	endtask

	task automatic test_random_traffic(input int unsigned n_items);
		for (int unsigned i = 0; i < n_items; i++)
			send_random_request();
	endtask

	// Random requests with both channels never idling on purpose.
	task automatic test_back_to_back(input int unsigned n_items);
		no_idle = 1'b1;
		for (int unsigned i = 0; i < n_items; i++)
			send_random_request();
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void note_mismatch(input string what, input cda_pkg::res_t want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t: %s: expected y=%0d m=%0d d=%0d days=%0d st=%0d",
				$time, what, want.year, want.month, want.day, want.days, want.status);
			$display("    got y=%0d m=%0d d=%0d days=%0d st=%0d",
				res_year, res_month, res_day, res_days, status);
		end
	endfunction

	function automatic void check_result();
		cda_pkg::res_t want;
		if (expected_results.size() == 0) begin
			note_mismatch("result item with nothing expected", '0);
			return;
		end
		want = expected_results.pop_front();
		if (res_year != want.year || res_month != want.month || res_day != want.day
				|| res_days != want.days || status != want.status)
			note_mismatch("result item mismatch", want);
	endfunction

	// Takes result items with random stalls and checks each one.
	initial begin : result_monitor
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready)
				check_result();
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				res_ready <= (stall_left == 0);
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Main sequence.
	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_add_days();
		test_subtract_days();
		test_difference();
		test_day_of_year();
		test_invalid_dates();
		test_random_traffic(50);
		test_back_to_back(24);
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("** calendar_date_arithmetic_top: PASSED **");
		end else begin
			$display("** calendar_date_arithmetic_top: FAILED **");
		end
		$finish;
	end

	// Run limit, far above the slowest legal run.
	initial begin : watchdog
		#10_000_000;
		$display("** calendar_date_arithmetic_top: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
src/cda_pkg.sv
src/cda_alu.sv
src/cda_seq.sv
src/calendar_date_arithmetic_top.sv
sim/calendar_date_arithmetic_top_tb.sv
